### design/median_and_mad_engine_macros.svh
// Assertion macros shared by the median / MAD engine modules.
`ifndef MEDIAN_AND_MAD_ENGINE_MACROS_SVH
`define MEDIAN_AND_MAD_ENGINE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MME_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define MME_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define MME_ASSERT(lbl, clk, rst, prop)
`define MME_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

### design/mme_pkg.sv
// Shared types and constants for the median / MAD engine.
package mme_pkg;

  localparam int CNT_BITS = 13;

  typedef struct packed {
    logic [CNT_BITS-1:0] count;
    logic                drop;
  } job_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_NEXT,
    ST_DONE
  } back_state_t;

endpackage

### design/mme_job_fifo.sv
// Two-entry queue of batch descriptors between the load and compute sides.
module mme_job_fifo (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  mme_pkg::job_t push_data,
  input  logic         pop,
  output mme_pkg::job_t pop_data,
  output logic         empty,
  output logic         full
);

  mme_pkg::job_t entry [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    used;

  assign empty    = (used == 2'd0);
  assign full     = (used == 2'd2);
  assign pop_data = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      used   <= 2'd0;
    end else begin
      if (push && !full) wr_ptr <= ~wr_ptr;
      if (pop && !empty) rd_ptr <= ~rd_ptr;
      case ({push && !full, pop && !empty})
        2'b10:   used <= used + 2'd1;
        2'b01:   used <= used - 2'd1;
        default: used <= used;
      endcase
    end
  end

endmodule

### design/mme_front.sv
// Load side: accepts samples into the sample memory and closes batches.
`include "median_and_mad_engine_macros.svh"
module mme_front #(
  parameter int MAX_SAMPLES = 512,
  parameter int SAMPLE_BITS = 20,
  parameter int AW          = $clog2(MAX_SAMPLES),
  parameter int CW          = $clog2(MAX_SAMPLES + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  logic                   in_last,
  output logic                   job_push,
  output mme_pkg::job_t          job_data,
  input  logic                   job_full,
  input  logic                   batch_done,
  input  logic [AW-1:0]          rd_addr,
  output logic [SAMPLE_BITS-1:0] rd_data
);

  logic [SAMPLE_BITS-1:0] mem [MAX_SAMPLES];
  logic [CW-1:0]          fill;
  logic                   drop;
  logic                   hold;
  logic                   accept;
  logic                   room;
  logic [CW-1:0]          fill_next;
  logic                   drop_next;

  assign in_ready  = !hold && !job_full;
  assign accept    = in_valid && in_ready;
  assign room      = (fill < CW'(MAX_SAMPLES));
  assign fill_next = room ? fill + CW'(1) : fill;
  assign drop_next = drop || !room;

  assign job_push       = accept && in_last;
  assign job_data.count = mme_pkg::CNT_BITS'(fill_next);
  assign job_data.drop  = drop_next;

  always_ff @(posedge clk) begin
    if (accept && room) begin
      mem[fill[AW-1:0]] <= in_sample;
    end
    rd_data <= mem[rd_addr];
  end

  // hold keeps the memory frozen until the compute side has finished the batch
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      drop <= 1'b0;
      hold <= 1'b0;
    end else begin
      if (accept) begin
        fill <= in_last ? '0 : fill_next;
        drop <= in_last ? 1'b0 : drop_next;
      end
      if (job_push) begin
        hold <= 1'b1;
      end else if (batch_done) begin
        hold <= 1'b0;
      end
    end
  end

  `MME_ASSERT(a_fill_bound, clk, rst, fill <= CW'(MAX_SAMPLES))
  `MME_ASSERT(a_no_load_while_hold, clk, rst, hold |-> !accept)
  `MME_ASSERT(a_push_sets_hold, clk, rst, job_push |=> hold)

endmodule

### design/mme_back.sv
// Compute side: bitwise radix selection of the median, then of the deviations.
`include "median_and_mad_engine_macros.svh"
module mme_back #(
  parameter int MAX_SAMPLES = 512,
  parameter int SAMPLE_BITS = 20,
  parameter int AW          = $clog2(MAX_SAMPLES),
  parameter int CW          = $clog2(MAX_SAMPLES + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   job_empty,
  input  mme_pkg::job_t          job_data,
  output logic                   job_pop,
  output logic [AW-1:0]          rd_addr,
  input  logic [SAMPLE_BITS-1:0] rd_data,
  output logic                   batch_done,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SAMPLE_BITS:0]   out_median,
  output logic [SAMPLE_BITS+1:0] out_mad,
  output logic [CW-1:0]          out_count,
  output logic                   out_drop
);

  localparam int VW = SAMPLE_BITS + 1;
  localparam int BW = $clog2(VW);

  mme_pkg::back_state_t state, state_next;

  logic          phase, phase_next;
  logic [BW-1:0] bitn, bitn_next;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] n, n_next;
  logic          drop, drop_next;
  logic [CW-1:0] ra, ra_next, rb, rb_next;
  logic [CW-1:0] ca, ca_next, cb, cb_next;
  logic [VW-1:0] pa, pa_next, pb, pb_next;
  logic [VW-1:0] med2, med2_next;
  logic [VW:0]   mad4, mad4_next;
  logic          rd_valid, rd_last;
  logic          issue;
  logic [VW-1:0] x2, dev, v, low_mask;
  logic          match_a, match_b;
  logic          bit_a, bit_b;
  logic [VW-1:0] pa_set, pb_set;
  logic [CW-1:0] half, rank_lo;
  logic          load_out;

  assign rd_addr  = idx[AW-1:0];
  assign issue    = (state == mme_pkg::ST_RUN) && (idx < n);
  assign x2       = {rd_data, 1'b0};
  assign dev      = (x2 >= med2) ? x2 - med2 : med2 - x2;
  assign v        = phase ? dev : {1'b0, rd_data};
  assign low_mask = (VW'(2) << bitn) - VW'(1);
  assign match_a  = (((v ^ pa) & ~low_mask) == '0) && !v[bitn];
  assign match_b  = (((v ^ pb) & ~low_mask) == '0) && !v[bitn];
  assign bit_a    = !(ra < ca);
  assign bit_b    = !(rb < cb);
  assign pa_set   = pa | (VW'(bit_a) << bitn);
  assign pb_set   = pb | (VW'(bit_b) << bitn);
  assign half     = n >> 1;
  assign rank_lo  = n[0] ? half : half - CW'(1);

  always_comb begin
    state_next = state;
    phase_next = phase;
    bitn_next  = bitn;
    idx_next   = idx;
    n_next     = n;
    drop_next  = drop;
    ra_next    = ra;
    rb_next    = rb;
    ca_next    = ca;
    cb_next    = cb;
    pa_next    = pa;
    pb_next    = pb;
    med2_next  = med2;
    mad4_next  = mad4;
    job_pop    = 1'b0;
    load_out   = 1'b0;
    case (state)
      mme_pkg::ST_IDLE: begin
        if (!job_empty) begin
          job_pop    = 1'b1;
          n_next     = CW'(job_data.count);
          drop_next  = job_data.drop;
          ra_next    = job_data.count[0] ? CW'(job_data.count >> 1)
                                         : CW'(job_data.count >> 1) - CW'(1);
          rb_next    = CW'(job_data.count >> 1);
          phase_next = 1'b0;
          bitn_next  = BW'(VW - 1);
          idx_next   = '0;
          ca_next    = '0;
          cb_next    = '0;
          pa_next    = '0;
          pb_next    = '0;
          state_next = mme_pkg::ST_RUN;
        end
      end
      mme_pkg::ST_RUN: begin
        if (issue) idx_next = idx + CW'(1);
        if (rd_valid) begin
          if (match_a) ca_next = ca + CW'(1);
          if (match_b) cb_next = cb + CW'(1);
          if (rd_last) state_next = mme_pkg::ST_NEXT;
        end
      end
      mme_pkg::ST_NEXT: begin
        idx_next = '0;
        ca_next  = '0;
        cb_next  = '0;
        if (bit_a) ra_next = ra - ca;
        if (bit_b) rb_next = rb - cb;
        pa_next    = pa_set;
        pb_next    = pb_set;
        bitn_next  = bitn - BW'(1);
        state_next = mme_pkg::ST_RUN;
        if (bitn == '0) begin
          if (!phase) begin
            med2_next  = pa_set + pb_set;
            phase_next = 1'b1;
            bitn_next  = BW'(VW - 1);
            pa_next    = '0;
            pb_next    = '0;
            ra_next    = rank_lo;
            rb_next    = half;
          end else begin
            mad4_next  = {1'b0, pa_set} + {1'b0, pb_set};
            state_next = mme_pkg::ST_DONE;
          end
        end
      end
      mme_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = mme_pkg::ST_IDLE;
        end
      end
      default: state_next = mme_pkg::ST_IDLE;
    endcase
  end

  assign batch_done = load_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mme_pkg::ST_IDLE;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= issue;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    phase   <= phase_next;
    bitn    <= bitn_next;
    idx     <= idx_next;
    n       <= n_next;
    drop    <= drop_next;
    ra      <= ra_next;
    rb      <= rb_next;
    ca      <= ca_next;
    cb      <= cb_next;
    pa      <= pa_next;
    pb      <= pb_next;
    med2    <= med2_next;
    mad4    <= mad4_next;
    rd_last <= (idx == n - CW'(1));
    if (load_out) begin
      out_median <= med2;
      out_mad    <= mad4;
      out_count  <= n;
      out_drop   <= drop;
    end
  end

  `MME_ASSERT(a_read_in_run, clk, rst, rd_valid |-> state == mme_pkg::ST_RUN)
  `MME_ASSERT(a_load_free, clk, rst, load_out |-> !(out_valid && !out_ready))
  `MME_ASSERT(a_count_nonzero, clk, rst, (state == mme_pkg::ST_RUN) |-> n != '0)

endmodule

### design/median_and_mad_engine.sv
// Median and MAD engine: one batch of N samples -> one result.
// Load: one sample per cycle while s_tready is high; the batch closing item is accepted in the same cycle.
// Compute: 2*(SAMPLE_BITS+1) radix passes over the sample memory, each reading every sample
// once, between a start step and a delivery step.
// The sample memory has a single read port; loading stalls meanwhile.
// Synchronous active-high rst clears control; memory contents are undefined until written.
module median_and_mad_engine #(
  parameter int MAX_SAMPLES = 512,
  parameter int SAMPLE_BITS = 20,
  localparam int CW         = $clog2(MAX_SAMPLES + 1),
  localparam int IDW        = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int ODW        = ((2 * SAMPLE_BITS + 4 + CW + 7) / 8) * 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [IDW-1:0] s_tdata,  // sample
  input  logic           s_tlast,  // last_sample
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [ODW-1:0] m_tdata   // median_x2, mad_x4, sample_count, overflowed
);

  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int OW = 2 * SAMPLE_BITS + 4 + CW;

  mme_pkg::job_t          push_data, pop_data;
  logic                   job_push, job_pop, job_empty, job_full;
  logic                   batch_done;
  logic [AW-1:0]          rd_addr;
  logic [SAMPLE_BITS-1:0] rd_data;
  logic [SAMPLE_BITS:0]   median;
  logic [SAMPLE_BITS+1:0] mad;
  logic [CW-1:0]          count;
  logic                   drop;

  mme_front #(.MAX_SAMPLES(MAX_SAMPLES), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk, .rst,
    .in_valid(s_tvalid), .in_ready(s_tready),
    .in_sample(s_tdata[SAMPLE_BITS-1:0]), .in_last(s_tlast),
    .job_push, .job_data(push_data), .job_full,
    .batch_done, .rd_addr, .rd_data
  );

  mme_job_fifo u_queue (
    .clk, .rst,
    .push(job_push), .push_data,
    .pop(job_pop), .pop_data,
    .empty(job_empty), .full(job_full)
  );

  mme_back #(.MAX_SAMPLES(MAX_SAMPLES), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
    .clk, .rst,
    .job_empty, .job_data(pop_data), .job_pop,
    .rd_addr, .rd_data, .batch_done,
    .out_valid(m_tvalid), .out_ready(m_tready),
    .out_median(median), .out_mad(mad), .out_count(count), .out_drop(drop)
  );

  assign m_tdata = {{(ODW - OW){1'b0}}, drop, count, mad, median};

endmodule
